### rtl/core/itt_pkg.sv
// itt_pkg: shared types and codes for the three-channel interval timer
package itt_pkg;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [2:0] PORT_CTRL = 3'd3;
  localparam logic [2:0] PORT_SYS  = 3'd4;

  localparam logic [1:0] SC_READBACK = 2'b11;
  localparam logic [1:0] RW_LATCH    = 2'd0;
  localparam logic [1:0] RW_LOW      = 2'd1;
  localparam logic [1:0] RW_HIGH     = 2'd2;
  localparam logic [1:0] RW_LOW_HIGH = 2'd3;

  localparam logic [2:0] MODE_INT_ON_TC = 3'd0;

  localparam int unsigned MAX_CHANNELS = 3;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned COUNT_W      = 16;

  typedef struct packed {
    logic              tick;
    logic              wr;
    logic              rd;
    logic              prog;
    logic              latch_cnt;
    logic              latch_sts;
    logic              gate;
    logic              gate_rise;
    logic              gate_fall;
    logic [BYTE_W-1:0] data;
  } itt_cmd_t;

endpackage

### rtl/core/itt_chan.sv
// itt_chan: one counter channel with its count, latches and byte sequencing
module itt_chan
  import itt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  itt_cmd_t          cmd,
  output logic [BYTE_W-1:0] rd_data,
  output logic              out_lvl
);

  logic [COUNT_W-1:0] reload_r, reload_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] latched_r, latched_nxt;
  logic               cnt_lat_r, cnt_lat_nxt;
  logic [BYTE_W-1:0]  status_r, status_nxt;
  logic               sts_lat_r, sts_lat_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic [1:0]         acc_r, acc_nxt;
  logic               wtog_r, wtog_nxt;
  logic               rtog_r, rtog_nxt;
  logic               out_r, out_nxt;
  logic               null_r, null_nxt;
  logic               armed_r, armed_nxt;
  logic               pend_r, pend_nxt;

  logic               periodic;
  logic               is_rate;
  logic [COUNT_W:0]   v;
  logic [COUNT_W:0]   v_m1;
  logic [COUNT_W:0]   step;
  logic [COUNT_W:0]   v_ms;
  logic [COUNT_W-1:0] rd_src;
  logic               wr_done;
  logic               rd_last;

  assign periodic = mode_r[1];
  assign is_rate  = (mode_r[1:0] == 2'd2);
  assign v        = (count_r == '0) ? {1'b1, {COUNT_W{1'b0}}} : {1'b0, count_r};
  assign v_m1     = v - (COUNT_W+1)'(1);
  assign step     = v[0] ? (out_r ? (COUNT_W+1)'(1) : (COUNT_W+1)'(3)) : (COUNT_W+1)'(2);
  assign v_ms     = v - step;
  assign rd_src   = cnt_lat_r ? latched_r : count_r;

  always_comb begin
    reload_nxt  = reload_r;
    count_nxt   = count_r;
    latched_nxt = latched_r;
    cnt_lat_nxt = cnt_lat_r;
    status_nxt  = status_r;
    sts_lat_nxt = sts_lat_r;
    mode_nxt    = mode_r;
    acc_nxt     = acc_r;
    wtog_nxt    = wtog_r;
    rtog_nxt    = rtog_r;
    out_nxt     = out_r;
    null_nxt    = null_r;
    armed_nxt   = armed_r;
    pend_nxt    = pend_r;
    rd_data     = '0;
    wr_done     = 1'b0;
    rd_last     = 1'b1;

    if (cmd.tick) begin
      if (periodic && armed_r) begin
        if (pend_r) begin
          count_nxt = reload_r;
          null_nxt  = 1'b0;
          pend_nxt  = 1'b0;
          out_nxt   = 1'b1;
        end else if (cmd.gate) begin
          if (is_rate) begin
            if (v == (COUNT_W+1)'(1)) begin
              count_nxt = reload_r;
              null_nxt  = 1'b0;
              out_nxt   = 1'b1;
            end else begin
              count_nxt = v_m1[COUNT_W-1:0];
              out_nxt   = (v_m1 != (COUNT_W+1)'(1));
            end
          end else if (v <= step) begin
            out_nxt   = ~out_r;
            count_nxt = reload_r;
            null_nxt  = 1'b0;
          end else begin
            count_nxt = v_ms[COUNT_W-1:0];
          end
        end
      end
    end

    if (cmd.wr) begin
      case (acc_r)
        RW_LOW: begin
          reload_nxt = {8'h00, cmd.data};
          wr_done    = 1'b1;
        end
        RW_HIGH: begin
          reload_nxt = {cmd.data, 8'h00};
          wr_done    = 1'b1;
        end
        default: begin
          if (!wtog_r) begin
            reload_nxt = {reload_r[15:8], cmd.data};
            wtog_nxt   = 1'b1;
          end else begin
            reload_nxt = {cmd.data, reload_r[7:0]};
            wtog_nxt   = 1'b0;
            wr_done    = 1'b1;
          end
        end
      endcase
      if (wr_done) begin
        null_nxt = 1'b1;
        if (periodic && !armed_r) begin
          armed_nxt = 1'b1;
          pend_nxt  = 1'b1;
        end
      end
    end

    if (cmd.rd) begin
      if (sts_lat_r) begin
        sts_lat_nxt = 1'b0;
        rd_data     = status_r;
      end else begin
        case (acc_r)
          RW_LOW:  rd_data = rd_src[7:0];
          RW_HIGH: rd_data = rd_src[15:8];
          default: begin
            if (!rtog_r) begin
              rd_data  = rd_src[7:0];
              rtog_nxt = 1'b1;
              rd_last  = 1'b0;
            end else begin
              rd_data  = rd_src[15:8];
              rtog_nxt = 1'b0;
            end
          end
        endcase
        if (rd_last) begin
          cnt_lat_nxt = 1'b0;
        end
      end
    end

    if (cmd.latch_cnt && !cnt_lat_r) begin
      latched_nxt = count_r;
      cnt_lat_nxt = 1'b1;
    end

    if (cmd.latch_sts && !sts_lat_r) begin
      status_nxt  = {out_r, null_r, acc_r, mode_r, 1'b0};
      sts_lat_nxt = 1'b1;
    end

    if (cmd.prog) begin
      acc_nxt     = cmd.data[5:4];
      mode_nxt    = cmd.data[3:1];
      wtog_nxt    = 1'b0;
      rtog_nxt    = 1'b0;
      out_nxt     = (cmd.data[3:1] != MODE_INT_ON_TC);
      null_nxt    = 1'b1;
      armed_nxt   = 1'b0;
      pend_nxt    = 1'b0;
      cnt_lat_nxt = 1'b0;
      sts_lat_nxt = 1'b0;
    end

    if (periodic) begin
      if (cmd.gate_fall) begin
        out_nxt = 1'b1;
      end else if (cmd.gate_rise && armed_r) begin
        pend_nxt = 1'b1;
      end
    end
  end

  assign out_lvl = out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r  <= '0;
      count_r   <= '0;
      latched_r <= '0;
      cnt_lat_r <= 1'b0;
      status_r  <= '0;
      sts_lat_r <= 1'b0;
      mode_r    <= '0;
      acc_r     <= RW_LOW_HIGH;
      wtog_r    <= 1'b0;
      rtog_r    <= 1'b0;
      out_r     <= 1'b1;
      null_r    <= 1'b1;
      armed_r   <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      reload_r  <= reload_nxt;
      count_r   <= count_nxt;
      latched_r <= latched_nxt;
      cnt_lat_r <= cnt_lat_nxt;
      status_r  <= status_nxt;
      sts_lat_r <= sts_lat_nxt;
      mode_r    <= mode_nxt;
      acc_r     <= acc_nxt;
      wtog_r    <= wtog_nxt;
      rtog_r    <= rtog_nxt;
      out_r     <= out_nxt;
      null_r    <= null_nxt;
      armed_r   <= armed_nxt;
      pend_r    <= pend_nxt;
    end
  end

endmodule

### rtl/core/interval_timer_three_channel_top.sv
// interval_timer_three_channel_top: three-channel interval timer with stream ports
// output register: the result of an input transfer is on the output in the next cycle
// throughput: one transfer per cycle unless stalled; state updates at the accepting edge
// a result waiting on out_tready holds in_tready low until that result is taken
// reset: synchronous rst_n clears all channel state, system port and output valid
module interval_timer_three_channel_top
  import itt_pkg::*;
#(
  parameter int unsigned NUMBER_CHANNELS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // write_data[7:0]
  input  logic [4:0]  in_tuser,   // action[1:0], port[4:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_data[7:0], out0[8], out1[9], out2[10], speaker[11]
);

  logic                  in_xfer;
  logic [1:0]            action;
  logic [2:0]            port;
  logic [BYTE_W-1:0]     wdata;
  logic                  is_wr;
  logic                  is_rd;
  logic                  ctrl_wr;
  logic                  sys_wr;
  logic [1:0]            sys_r, sys_nxt;
  logic [MAX_CHANNELS-1:0] lvl;
  logic [BYTE_W-1:0]     chan_rd [NUMBER_CHANNELS];
  logic [BYTE_W-1:0]     rd_byte;

  logic                  out_valid_r;
  logic [BYTE_W-1:0]     rd_r;
  logic [MAX_CHANNELS-1:0] lvl_r;
  logic                  spk_r;

  assign action  = in_tuser[1:0];
  assign port    = in_tuser[4:2];
  assign wdata   = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer = in_tvalid && in_tready;
  assign is_wr   = in_xfer && (action == ACT_WRITE);
  assign is_rd   = in_xfer && (action == ACT_READ);
  assign ctrl_wr = is_wr && (port == PORT_CTRL);
  assign sys_wr  = is_wr && (port == PORT_SYS);
  assign sys_nxt = sys_wr ? wdata[1:0] : sys_r;

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_chan
    if (c < NUMBER_CHANNELS) begin : g_on
      itt_cmd_t cmd;
      logic     sel_rb;
      logic     sel_cw;

      assign sel_rb = ctrl_wr && (wdata[7:6] == SC_READBACK) && wdata[c+1];
      assign sel_cw = ctrl_wr && (wdata[7:6] == 2'(c));

      always_comb begin
        cmd           = '0;
        cmd.data      = wdata;
        cmd.tick      = in_xfer && (action == ACT_TICK);
        cmd.wr        = is_wr && (port == 3'(c));
        cmd.rd        = is_rd && (port == 3'(c));
        cmd.prog      = sel_cw && (wdata[5:4] != RW_LATCH);
        cmd.latch_cnt = (sel_rb && !wdata[5]) || (sel_cw && (wdata[5:4] == RW_LATCH));
        cmd.latch_sts = sel_rb && !wdata[4];
        cmd.gate      = (c == 2) ? sys_r[0] : 1'b1;
        cmd.gate_rise = (c == 2) && sys_wr && !sys_r[0] && wdata[0];
        cmd.gate_fall = (c == 2) && sys_wr && sys_r[0] && !wdata[0];
      end

      itt_chan u_chan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_data (chan_rd[c]),
        .out_lvl (lvl[c])
      );
    end else begin : g_off
      assign lvl[c] = 1'b0;
    end
  end

  always_comb begin
    rd_byte = '0;
    if (is_rd) begin
      if (port == PORT_SYS) begin
        rd_byte = {6'b0, sys_r};
      end
      for (int c = 0; c < NUMBER_CHANNELS; c++) begin
        if (port == 3'(c)) begin
          rd_byte = chan_rd[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sys_r <= sys_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_r  <= rd_byte;
      lvl_r <= lvl;
      spk_r <= lvl[2] && sys_nxt[1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, spk_r, lvl_r, rd_r};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  a_sys_read_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (is_rd && (port == PORT_SYS)) |=> (out_tdata[7:2] == 6'b0))
    else $error("system port read returned upper bits");

  a_no_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (action != ACT_READ)) |=> (out_tdata[7:0] == 8'h00))
    else $error("read data nonzero on a non-read transfer");

  a_speaker_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_tdata[11] || out_tdata[10]))
    else $error("speaker high while out2 low");

endmodule
